>>> rtl/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int MAX_LINE_DEF  = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_NO_LINE_END = 2'd0;
    localparam logic [1:0] ERR_LINE_LEN    = 2'd1;
    localparam logic [1:0] ERR_SIZE_VALUE  = 2'd2;
    localparam logic [1:0] ERR_NO_DELIM    = 2'd3;

    // work for the back end from one request: optional payload byte, then optional closing result
    typedef struct packed {
        logic       pay_valid;
        logic [7:0] pay_byte;
        logic       term_valid;
        logic [1:0] term_kind;
        logic [1:0] term_code;
    } hcbd_op_t;

endpackage

`default_nettype wire

>>> rtl/hcbd_front.sv
`default_nettype none

module hcbd_front
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int MAX_LINE  = MAX_LINE_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_last,
    input  wire logic [7:0] in_byte,
    input  wire logic     q_full,
    output logic          push,
    output hcbd_op_t      push_op
);

    localparam logic [2:0] PH_LINE = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd1;
    localparam logic [2:0] PH_DCR  = 3'd2;
    localparam logic [2:0] PH_DLF  = 3'd3;
    localparam logic [2:0] PH_IDLE = 3'd4;

    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_SEMI = 8'h3b;

    localparam logic [5:0] LEN_SAT = 6'd63;

    typedef struct packed {
        logic [5:0]           len;
        logic                 semi;
        logic                 bad;
        logic                 ovf;
        logic                 digit;
        logic [SIZE_BITS-1:0] size;
    } line_t;

    logic [2:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    line_t                line_reg, line_next;
    logic                 cr_pending_reg, cr_pending_next;
    logic                 accept;
    hcbd_op_t             op;
    line_t                tmp;
    logic [SIZE_BITS-1:0] dec;

    function automatic line_t line_content(line_t st, logic [7:0] c);
        line_t      r;
        logic       hv;
        logic [3:0] dv;
        r  = st;
        hv = 1'b0;
        dv = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            hv = 1'b1;
            dv = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            hv = 1'b1;
            dv = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            hv = 1'b1;
            dv = 4'(c - 8'h37);
        end
        if (st.len != LEN_SAT)
            r.len = st.len + 6'd1;
        if (!st.semi)
        begin
            priority if (c == CH_SEMI)
                r.semi = 1'b1;
            else if (!hv)
                r.bad = 1'b1;
            else if (st.size[SIZE_BITS-1 -: 4] != 4'd0)
                r.ovf = 1'b1;
            else
            begin
                r.size  = {st.size[SIZE_BITS-5:0], dv};
                r.digit = 1'b1;
            end
        end
        return r;
    endfunction

    assign accept = in_valid && !q_full;
    assign push   = accept && (op.pay_valid || op.term_valid);
    assign push_op = op;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        line_next       = line_reg;
        cr_pending_next = cr_pending_reg;
        op              = '0;
        tmp             = line_reg;
        dec             = bytes_left_reg;
        unique case (phase_reg)
            PH_LINE:
            begin
                if (cr_pending_reg && in_byte == CH_LF)
                begin
                    op.term_kind = KIND_ERROR;
                    priority if (line_reg.len == 6'd0 || line_reg.len >= 6'(MAX_LINE))
                    begin
                        op.term_valid = 1'b1;
                        op.term_code  = ERR_LINE_LEN;
                        phase_next    = PH_IDLE;
                    end
                    else if (!line_reg.digit || line_reg.bad || line_reg.ovf)
                    begin
                        op.term_valid = 1'b1;
                        op.term_code  = ERR_SIZE_VALUE;
                        phase_next    = PH_IDLE;
                    end
                    else if (line_reg.size == '0)
                    begin
                        op.term_valid = 1'b1;
                        op.term_kind  = KIND_DONE;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        bytes_left_next = line_reg.size;
                        phase_next      = PH_DATA;
                    end
                    line_next       = '0;
                    cr_pending_next = 1'b0;
                end
                else
                begin
                    // a CR not followed by LF counts as a line byte
                    if (cr_pending_reg)
                        tmp = line_content(tmp, CH_CR);
                    if (in_byte == CH_CR)
                        cr_pending_next = 1'b1;
                    else
                    begin
                        cr_pending_next = 1'b0;
                        tmp = line_content(tmp, in_byte);
                    end
                    line_next = tmp;
                end
            end
            PH_DATA:
            begin
                op.pay_valid = 1'b1;
                op.pay_byte  = in_byte;
                if (bytes_left_reg != '0)
                    dec = bytes_left_reg - 1'b1;
                bytes_left_next = dec;
                if (dec == '0)
                    phase_next = PH_DCR;
            end
            PH_DCR:
            begin
                if (in_byte == CH_CR)
                    phase_next = PH_DLF;
                else
                begin
                    op.term_valid = 1'b1;
                    op.term_kind  = KIND_ERROR;
                    op.term_code  = ERR_NO_DELIM;
                    phase_next    = PH_IDLE;
                end
            end
            PH_DLF:
            begin
                if (in_byte == CH_LF)
                begin
                    phase_next      = PH_LINE;
                    line_next       = '0;
                    cr_pending_next = 1'b0;
                end
                else
                begin
                    op.term_valid = 1'b1;
                    op.term_kind  = KIND_ERROR;
                    op.term_code  = ERR_NO_DELIM;
                    phase_next    = PH_IDLE;
                end
            end
            default:
                phase_next = PH_IDLE;
        endcase
        if (in_last)
        begin
            if (phase_next != PH_IDLE)
            begin
                op.term_valid = 1'b1;
                op.term_kind  = KIND_ERROR;
                op.term_code  = (phase_next == PH_LINE) ? ERR_NO_LINE_END : ERR_NO_DELIM;
            end
            phase_next      = PH_LINE;
            bytes_left_next = '0;
            line_next       = '0;
            cr_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LINE;
            bytes_left_reg <= '0;
            line_reg       <= '0;
            cr_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            line_reg       <= line_next;
            cr_pending_reg <= cr_pending_next;
        end
    end

    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("payload phase with nothing left");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> phase_reg == PH_LINE && !cr_pending_reg)
        else $error("last request did not return to size line");

    a_one_term_done: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_op.term_valid && push_op.term_kind == KIND_DONE |-> !push_op.pay_valid)
        else $error("done result paired with payload");

endmodule

`default_nettype wire

>>> rtl/hcbd_queue.sv
`default_nettype none

module hcbd_queue
    import hcbd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire hcbd_op_t  push_op,
    input  wire logic      pop,
    output logic           full,
    output logic           not_empty,
    output hcbd_op_t       head_op
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hcbd_op_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= PTR_W'((wr_ptr_reg + 1'b1) % QUEUE_DEPTH);
            if (pop)
                rd_ptr_reg <= PTR_W'((rd_ptr_reg + 1'b1) % QUEUE_DEPTH);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && full |-> pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

>>> rtl/hcbd_back.sv
`default_nettype none

module hcbd_back
    import hcbd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    input  wire hcbd_op_t  head_op,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [15:0]    out_data,
    output logic [1:0]     out_user,
    output logic           out_last
);

    logic        valid_reg, valid_next;
    logic        pay_done_reg, pay_done_next;
    logic [15:0] data_reg, data_next;
    logic [1:0]  user_reg, user_next;
    logic        last_reg, last_next;
    logic        load;

    assign load      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        pop           = 1'b0;
        valid_next    = valid_reg;
        pay_done_next = pay_done_reg;
        data_next     = data_reg;
        user_next     = user_reg;
        last_next     = last_reg;
        if (load)
        begin
            valid_next = q_valid;
            if (q_valid)
            begin
                if (head_op.pay_valid && !pay_done_reg)
                begin
                    data_next = {8'd0, head_op.pay_byte};
                    user_next = KIND_PAYLOAD;
                    last_next = 1'b0;
                    if (head_op.term_valid)
                        pay_done_next = 1'b1;
                    else
                        pop = 1'b1;
                end
                else
                begin
                    data_next     = {6'd0, head_op.term_code, 8'd0};
                    user_next     = head_op.term_kind;
                    last_next     = 1'b1;
                    pay_done_next = 1'b0;
                    pop           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            pay_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            pay_done_reg <= pay_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    a_payload_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && user_reg == KIND_PAYLOAD |-> !last_reg)
        else $error("payload result marked last");

    a_split_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        pay_done_reg |-> q_valid && head_op.pay_valid && head_op.term_valid)
        else $error("split request lost its queue entry");

    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid && load)
        else $error("pop without a result loaded");

endmodule

`default_nettype wire

>>> rtl/http_chunked_body_decoder_unit.sv
// An accepted request enters the four-entry queue, then the registered m_axis output stage.
// Throughput: one request per cycle while the queue is not full; a request with a payload byte
// and a closing result gives two outputs, absorbed by the queue between parser and output stage.
// Reset (rst_n low, asynchronous): parser back to the size line, queue and output emptied.
// After the request marked last the parser returns to the same state on its own.
`default_nettype none

module http_chunked_body_decoder_unit
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int MAX_LINE  = MAX_LINE_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] payload_byte, [9:8] error_code
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // final_res
);

    logic     q_full;
    logic     q_not_empty;
    logic     push;
    logic     pop;
    hcbd_op_t push_op;
    hcbd_op_t head_op;

    assign s_axis_tready = !q_full;

    hcbd_front #(
        .SIZE_BITS (SIZE_BITS),
        .MAX_LINE  (MAX_LINE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_byte  (s_axis_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op)
    );

    hcbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_op   (head_op)
    );

    hcbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .head_op   (head_op),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> test/tb_http_chunked_body_decoder_unit.sv
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder_unit;

    import hcbd_pkg::*;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [1:0] CODE_NONE = 2'd0;

    typedef enum logic [2:0] {ST_LINE, ST_DATA, ST_DCR, ST_DLF, ST_IDLE} parse_st_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] code;
        logic       fin;
    } decoded_t;

    typedef struct {
        logic [7:0] data;
        logic       fin;
        logic       pause;
    } body_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    body_req_t   body_reqs[$];
    decoded_t    results_due[$];
    logic [7:0]  scratch[$];
    string       hex_set = "0123456789abcdefABCDEF";

    int          total_reqs = 0;
    int          bytes_taken = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          n_payload = 0;
    int          n_done = 0;
    int          n_error = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        rx_hold = 1'b0;

    // parser state as predicted
    parse_st_t   pst = ST_LINE;
    logic [5:0]  line_count = '0;
    logic [31:0] size_acc = '0;
    logic [31:0] left = '0;
    logic [3:0]  ndigits = '0;
    logic        semi = 1'b0;
    logic        bad = 1'b0;
    logic        ovf = 1'b0;
    logic        cr_seen = 1'b0;

    http_chunked_body_decoder_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always_comb
    begin
        case ((total_reqs == 0) ? 0 : bytes_taken * 3 / total_reqs)
            0:       begin send_idle_pct = 10; recv_idle_pct = 50; end
            1:       begin send_idle_pct = 50; recv_idle_pct = 10; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
    end

    task automatic note_result(input logic [1:0] kind, input logic [7:0] data,
                               input logic [1:0] code);
        decoded_t r;
        r.kind = kind;
        r.data = data;
        r.code = code;
        r.fin  = (kind != KIND_PAYLOAD);
        results_due.push_back(r);
    endtask

    task automatic clear_line();
        line_count = '0;
        size_acc   = '0;
        ndigits    = '0;
        semi       = 1'b0;
        bad        = 1'b0;
        ovf        = 1'b0;
        cr_seen    = 1'b0;
    endtask

    task automatic take_line_char(input logic [7:0] c);
        logic [3:0] nib;
        logic       is_hex;
        if (line_count != 6'd63)
            line_count++;
        if (semi)
            return;
        if (c == CH_SEMI)
        begin
            semi = 1'b1;
            return;
        end
        is_hex = 1'b1;
        nib = '0;
        if (c >= "0" && c <= "9")
            nib = c[3:0];
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            nib = c[3:0] + 4'd9;
        else
            is_hex = 1'b0;
        if (!is_hex)
        begin
            bad = 1'b1;
            return;
        end
        if (size_acc[31:28] != 4'd0)
        begin
            ovf = 1'b1;
            return;
        end
        size_acc = {size_acc[27:0], nib};
        if (ndigits != 4'd15)
            ndigits++;
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic fin);
        logic line_done;
        line_done = 1'b0;
        case (pst)
            ST_LINE:
            begin
                // a CR only ends the line when LF follows straight away
                if (cr_seen)
                begin
                    cr_seen = 1'b0;
                    if (c == CH_LF)
                        line_done = 1'b1;
                    else
                        take_line_char(CH_CR);
                end
                if (!line_done)
                begin
                    if (c == CH_CR)
                        cr_seen = 1'b1;
                    else
                        take_line_char(c);
                end
                if (line_done)
                begin
                    if (line_count == 0 || line_count >= MAX_LINE_DEF)
                    begin
                        note_result(KIND_ERROR, 8'd0, ERR_LINE_LEN);
                        pst = ST_IDLE;
                    end
                    else if (ndigits == 0 || bad || ovf)
                    begin
                        note_result(KIND_ERROR, 8'd0, ERR_SIZE_VALUE);
                        pst = ST_IDLE;
                    end
                    else if (size_acc == 0)
                    begin
                        note_result(KIND_DONE, 8'd0, CODE_NONE);
                        pst = ST_IDLE;
                    end
                    else
                    begin
                        left = size_acc;
                        pst = ST_DATA;
                    end
                    clear_line();
                end
            end
            ST_DATA:
            begin
                note_result(KIND_PAYLOAD, c, CODE_NONE);
                if (left != 0)
                    left--;
                if (left == 0)
                    pst = ST_DCR;
            end
            ST_DCR:
            begin
                if (c == CH_CR)
                    pst = ST_DLF;
                else
                begin
                    note_result(KIND_ERROR, 8'd0, ERR_NO_DELIM);
                    pst = ST_IDLE;
                end
            end
            ST_DLF:
            begin
                if (c == CH_LF)
                begin
                    pst = ST_LINE;
                    clear_line();
                end
                else
                begin
                    note_result(KIND_ERROR, 8'd0, ERR_NO_DELIM);
                    pst = ST_IDLE;
                end
            end
            default:
                pst = ST_IDLE;
        endcase
        if (fin)
        begin
            if (pst != ST_IDLE)
                note_result(KIND_ERROR, 8'd0,
                            (pst == ST_LINE) ? ERR_NO_LINE_END : ERR_NO_DELIM);
            pst = ST_LINE;
            left = '0;
            clear_line();
        end
    endtask

    task automatic put_byte(input logic [7:0] data, input logic fin);
        body_req_t r;
        r.data  = data;
        r.fin   = fin;
        r.pause = 1'b0;
        body_reqs.push_back(r);
    endtask

    // "\n" in s stands for CR LF
    task automatic put_str(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++)
        begin
            if (s[i] == "\n")
            begin
                put_byte(CH_CR, 1'b0);
                put_byte(CH_LF, fin && i == s.len() - 1);
            end
            else
                put_byte(s[i], fin && i == s.len() - 1);
        end
    endtask

    task automatic put_msg();
        foreach (scratch[i])
            put_byte(scratch[i], i == scratch.size() - 1);
    endtask

    task automatic add_size_line(input logic [31:0] sz);
        logic [7:0]  txt[$];
        logic [31:0] v;
        int          idx;
        int          room;
        v = sz;
        do
        begin
            idx = v[3:0];
            if (idx >= 10 && $urandom_range(0, 1) == 1)
                idx += 6;
            txt.push_front(hex_set[idx]);
            v = v >> 4;
        end
        while (v != 0);
        case ($urandom_range(0, 9))
            0:       while (txt.size() < MAX_LINE_DEF - 1) txt.push_front("0");
            1, 2:    repeat ($urandom_range(1, 3)) txt.push_front("0");
            default: ;
        endcase
        if (txt.size() < MAX_LINE_DEF - 2 && $urandom_range(0, 3) == 0)
        begin
            room = MAX_LINE_DEF - 2 - txt.size();
            txt.push_back(CH_SEMI);
            repeat ($urandom_range(0, (room > 6) ? 6 : room))
                txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        foreach (txt[i])
            scratch.push_back(txt[i]);
        scratch.push_back(CH_CR);
        scratch.push_back(CH_LF);
    endtask

    task automatic build_good_body();
        int sz;
        scratch.delete();
        repeat ($urandom_range(0, 3))
        begin
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            add_size_line(sz);
            repeat (sz) scratch.push_back(8'($urandom_range(0, 255)));
            scratch.push_back(CH_CR);
            scratch.push_back(CH_LF);
        end
        add_size_line(32'd0);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) scratch.push_back(8'($urandom));
    endtask

    initial
    begin
        int first_random;
        int cut;

        put_str("1\n", 1'b0);
        put_byte(8'hFF, 1'b0);
        put_str("\n0\n", 1'b1);
        put_str("\nx", 1'b1);                    // empty size line
        put_str("g\n", 1'b1);
        put_str(";e\n", 1'b1);                   // extension with no digit
        put_str("100000000\n", 1'b1);            // too wide for 32 bits
        repeat (MAX_LINE_DEF) put_byte("0", 1'b0);
        put_str("\n", 1'b1);                     // line too long, value fine
        put_str("1", 1'b0);
        put_byte(CH_CR, 1'b0);
        put_str("X\n", 1'b1);                    // lone CR is line content
        put_str("1\nAB", 1'b1);
        put_str("FFFFFFFF\n", 1'b0);
        put_byte(8'h00, 1'b1);                   // payload and error on one request
        put_str("3", 1'b1);
        put_str("1\nA\n", 1'b1);                 // ends on empty line after delimiter
        put_str("1\nA", 1'b0);
        put_byte(CH_CR, 1'b1);
        put_str("0\nz", 1'b1);

        first_random = body_reqs.size();
        while (body_reqs.size() - first_random < 300)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    build_good_body();
                    put_msg();
                end
                6, 7:
                begin
                    build_good_body();
                    cut = $urandom_range(0, scratch.size() - 1);
                    if ($urandom_range(0, 1) == 1)
                        scratch[cut] = 8'($urandom);
                    else
                        while (scratch.size() > cut + 1) void'(scratch.pop_back());
                    put_msg();
                end
                8:
                begin
                    scratch.delete();
                    repeat ($urandom_range(1, 12))
                        scratch.push_back(hex_set[$urandom_range(0, 21)]);
                    scratch.push_back(CH_CR);
                    scratch.push_back(CH_LF);
                    repeat ($urandom_range(0, 3)) scratch.push_back(8'($urandom));
                    put_msg();
                end
                default:
                begin
                    scratch.delete();
                    repeat ($urandom_range(1, 8)) scratch.push_back(8'($urandom_range(0, 255)));
                    put_msg();
                end
            endcase
        end
        body_reqs[first_random].pause = 1'b1;
        body_reqs[first_random + (body_reqs.size() - first_random) * 2 / 3].pause = 1'b1;
        total_reqs = body_reqs.size();
    end

    always @(posedge clk)
    begin : drive
        logic offer;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(body_reqs[0].data, body_reqs[0].fin);
                void'(body_reqs.pop_front());
                bytes_taken++;
            end
            if (s_axis_tvalid && !s_axis_tready)
                offer = 1'b1;
            else
                offer = body_reqs.size() != 0
                        && !(body_reqs[0].pause && results_due.size() != 0)
                        && $urandom_range(0, 99) >= send_idle_pct;
            s_axis_tvalid <= offer;
            if (offer)
            begin
                s_axis_tdata <= body_reqs[0].data;
                s_axis_tlast <= body_reqs[0].fin;
            end
        end
    end

    always @(posedge clk)
    begin : watch
        decoded_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d code %0d byte %h last %b",
                                 m_axis_tuser, m_axis_tdata[9:8], m_axis_tdata[7:0],
                                 m_axis_tlast);
                end
                else
                begin
                    want = results_due.pop_front();
                    case (want.kind)
                        KIND_PAYLOAD: n_payload++;
                        KIND_DONE:    n_done++;
                        default:      n_error++;
                    endcase
                    if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.data
                        || m_axis_tdata[9:8] !== want.code || m_axis_tlast !== want.fin)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected kind %0d code %0d byte %h",
                                      " last %b, got kind %0d code %0d byte %h last %b"},
                                     results_seen, want.kind, want.code, want.data,
                                     want.fin, m_axis_tuser, m_axis_tdata[9:8],
                                     m_axis_tdata[7:0], m_axis_tlast);
                    end
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long output stall so the block backs up and drops s_axis_tready
    initial
    begin
        wait (total_reqs != 0 && bytes_taken >= total_reqs / 2);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (80) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #2_400_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (total_reqs == 0 || body_reqs.size() != 0 || s_axis_tvalid
               || results_due.size() != 0);
        repeat (20) @(posedge clk);
        $display("%0d body bytes in, %0d results out: %0d payload, %0d done, %0d errors",
                 bytes_taken, results_seen, n_payload, n_done, n_error);
        $display("well-formed, corrupted, truncated and noise bodies under varied back-pressure");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
